// File: src/rgb_to_gray_or_hsv_pixel_defines.svh
// Assertion macros used by the checker file of the pixel converter.
`ifndef RGB_TO_GRAY_OR_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_GRAY_OR_HSV_PIXEL_DEFINES_SVH

// Property checked on every rising edge outside of reset.
`define RGBHSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define RGBHSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: src/rgbhsv_pkg.sv
// Shared types, constants and the divider step function of the pixel converter.
`default_nettype none

package rgbhsv_pkg;

  // Quotient width of both dividers; one quotient bit is resolved per pipeline stage.
  localparam int unsigned QuotBits = 8;
  localparam int unsigned QuotIdxW = $clog2(QuotBits);

  // Luma weights in 16-bit fixed point; they sum to exactly 65536.
  localparam logic [12:0] WeightB = 13'd7471;
  localparam logic [15:0] WeightG = 16'd38470;
  localparam logic [14:0] WeightR = 15'd19595;

  // Work carried through the divider pipeline for one beat.
  typedef struct packed {
    logic        mode;
    logic [7:0]  gray;
    logic [7:0]  max_val;
    logic        hue_zero;
    logic        sat_zero;
    logic [16:0] hue_rem;
    logic [8:0]  hue_div;
    logic [7:0]  hue_quot;
    logic [15:0] sat_rem;
    logic [7:0]  sat_div;
    logic [7:0]  sat_quot;
  } rgbhsv_div_t;

  // One restoring division step for both dividers at quotient bit idx.
  function automatic rgbhsv_div_t div_step(input rgbhsv_div_t s,
                                           input logic [QuotIdxW-1:0] idx);
    rgbhsv_div_t o;
    logic [16:0] hue_sh;
    logic [15:0] sat_sh;
    o      = s;
    hue_sh = 17'(s.hue_div) << idx;
    sat_sh = 16'(s.sat_div) << idx;
    if (s.hue_rem >= hue_sh) begin
      o.hue_rem       = s.hue_rem - hue_sh;
      o.hue_quot[idx] = 1'b1;
    end
    if (s.sat_rem >= sat_sh) begin
      o.sat_rem       = s.sat_rem - sat_sh;
      o.sat_quot[idx] = 1'b1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: src/rgbhsv_divider.sv
// Pipelined restoring divider for hue and saturation, one quotient bit per stage.
`default_nettype none

module rgbhsv_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  rgbhsv_pkg::rgbhsv_div_t  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rgbhsv_pkg::rgbhsv_div_t  out_data_o
);
  import rgbhsv_pkg::*;

  logic [QuotBits-1:0] valid_q;
  rgbhsv_div_t         data_q  [QuotBits];
  rgbhsv_div_t         stage_in[QuotBits];
  logic [QuotBits-1:0] stage_vin;
  logic [QuotBits:0]   ready;

  // The ready chain is resolved from the output end back to the input.
  always_comb begin
    ready[QuotBits] = !out_stall_i;
    for (int j = QuotBits - 1; j >= 0; j--) begin
      ready[j] = !valid_q[j] || ready[j+1];
      if (j == 0) begin
        stage_in[j]  = in_data_i;
        stage_vin[j] = in_valid_i;
      end else begin
        stage_in[j]  = data_q[j-1];
        stage_vin[j] = valid_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int j = 0; j < QuotBits; j++) begin
        if (ready[j]) begin
          valid_q[j] <= stage_vin[j];
        end
      end
    end
  end

  // Stage j resolves quotient bit QuotBits-1-j, most significant first.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QuotBits; j++) begin
      if (ready[j] && stage_vin[j]) begin
        data_q[j] <= div_step(stage_in[j], QuotIdxW'(QuotBits - 1 - j));
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[QuotBits-1];
  assign out_data_o  = data_q[QuotBits-1];

endmodule

`default_nettype wire

// File: src/rgb_to_gray_or_hsv_pixel.sv
// Top level of the BGR pixel converter to grayscale or HSV.
//
// Input channel: one BGR pixel per beat on blue_i, green_i and red_i, taken at a
// rising edge with in_valid_i high and in_stall_o low. Output channel: one
// converted pixel per beat, taken at a rising edge with out_valid_o high and
// out_stall_i low. The mode register (cfg_we_i, cfg_data_i) selects gray (0) or
// HSV (1); write it only while no pixel is in flight.
// From input beat to output valid, two stages find the
// channel maximum, the gray products and the hue numerator, then eight stages
// each resolve one quotient bit of the hue and saturation divisions.
// Throughput is one pixel per cycle while the receiver does not stall. When the receiver stalls, the pipeline
// keeps advancing into empty stages and only stops a stage whose successor is
// full, so bubbles are squeezed out and no beat is lost or repeated.
// Reset clears all stage valid bits and sets the mode to gray.
`default_nettype none

module rgb_to_gray_or_hsv_pixel (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] blue_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] gray_or_hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] brightness_o
);
  import rgbhsv_pkg::*;

  logic mode_q;

  // Stage 1: channel extremes, winner of the maximum, luma products.
  logic        s1_valid_q;
  logic        s1_mode_q;
  logic [7:0]  s1_b_q, s1_g_q, s1_r_q;
  logic [7:0]  s1_max_q, s1_min_q;
  logic        s1_rmax_q, s1_gmax_q;
  logic [20:0] s1_pb_q;
  logic [23:0] s1_pg_q;
  logic [22:0] s1_pr_q;
  logic [7:0]  max_d, min_d;

  // Stage 2: dividends and divisors ready for the divider.
  logic        s2_valid_q;
  rgbhsv_div_t s2_q, s2_d;
  logic [7:0]  diff;
  logic [16:0] hue_num;
  logic [23:0] gray_sum;

  logic        s1_ready, s2_ready, div_ready;
  rgbhsv_div_t div_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  assign s2_ready   = !s2_valid_q || div_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_comb begin
    max_d = red_i;
    if (green_i > max_d) max_d = green_i;
    if (blue_i > max_d) max_d = blue_i;
    min_d = red_i;
    if (green_i < min_d) min_d = green_i;
    if (blue_i < min_d) min_d = blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_mode_q <= mode_q;
      s1_b_q    <= blue_i;
      s1_g_q    <= green_i;
      s1_r_q    <= red_i;
      s1_max_q  <= max_d;
      s1_min_q  <= min_d;
      s1_rmax_q <= (red_i == max_d);
      s1_gmax_q <= (green_i == max_d);
      s1_pb_q   <= 21'(WeightB) * 21'(blue_i);
      s1_pg_q   <= 24'(WeightG) * 24'(green_i);
      s1_pr_q   <= 23'(WeightR) * 23'(red_i);
    end
  end

  // Hue numerator in degree units scaled by diff; the division by 2*diff gives the hue in two-degree units.
  always_comb begin
    diff     = s1_max_q - s1_min_q;
    gray_sum = 24'(s1_pb_q) + s1_pg_q + 24'(s1_pr_q);
    if (s1_rmax_q) begin
      if (s1_g_q >= s1_b_q) begin
        hue_num = 17'd60 * 17'(s1_g_q - s1_b_q);
      end else begin
        hue_num = 17'd360 * 17'(diff) - 17'd60 * 17'(s1_b_q - s1_g_q);
      end
    end else if (s1_gmax_q) begin
      hue_num = 17'd120 * 17'(diff) + 17'd60 * 17'(s1_b_q) - 17'd60 * 17'(s1_r_q);
    end else begin
      hue_num = 17'd240 * 17'(diff) + 17'd60 * 17'(s1_r_q) - 17'd60 * 17'(s1_g_q);
    end

    s2_d          = '0;
    s2_d.mode     = s1_mode_q;
    s2_d.gray     = gray_sum[23:16];
    s2_d.max_val  = s1_max_q;
    s2_d.hue_zero = (diff == 8'd0);
    s2_d.sat_zero = (s1_max_q == 8'd0);
    s2_d.hue_rem  = hue_num;
    s2_d.hue_div  = {diff, 1'b0};
    s2_d.sat_rem  = {diff, 8'd0} - 16'(diff);
    s2_d.sat_div  = s1_max_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  rgbhsv_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid_q),
    .in_ready_o  (div_ready),
    .in_data_i   (s2_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (div_out)
  );

  // A gray or black pixel divides by zero; those quotients are forced to zero.
  always_comb begin
    if (div_out.mode) begin
      gray_or_hue_o = div_out.hue_zero ? 8'd0 : div_out.hue_quot;
      saturation_o  = div_out.sat_zero ? 8'd0 : div_out.sat_quot;
      brightness_o  = div_out.max_val;
    end else begin
      gray_or_hue_o = div_out.gray;
      saturation_o  = 8'd0;
      brightness_o  = 8'd0;
    end
  end

endmodule

`default_nettype wire

// File: src/rgbhsv_checker.sv
// Port-level checker of the pixel converter and its bind to the top level.
`default_nettype none
`include "rgb_to_gray_or_hsv_pixel_defines.svh"

module rgbhsv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_data_i,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] blue_i,
  input logic [7:0] green_i,
  input logic [7:0] red_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] gray_or_hue_o,
  input logic [7:0] saturation_o,
  input logic [7:0] brightness_o
);

  logic out_hold;
  assign out_hold = out_valid_o && out_stall_i;

  // A stalled output beat stays valid and keeps its value.
  `RGBHSV_ASSERT(a_out_hold, out_hold |=> out_valid_o && $stable(gray_or_hue_o) && $stable(saturation_o) && $stable(brightness_o), "stalled output beat changed")

  // Zero brightness means gray mode or a black pixel, both with zero saturation.
  `RGBHSV_ASSERT(a_sat_needs_max, out_valid_o && brightness_o == 8'd0 |-> saturation_o == 8'd0, "saturation without brightness")

  // Nonzero brightness only occurs in HSV mode, where the hue stays below 180.
  `RGBHSV_ASSERT(a_hue_range, out_valid_o && brightness_o != 8'd0 |-> gray_or_hue_o < 8'd180, "hue out of range")

  // An edge seen with reset held leaves no output beat offered in the next cycle.
  `RGBHSV_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind rgb_to_gray_or_hsv_pixel rgbhsv_checker u_rgbhsv_checker (.*);

`default_nettype wire

// File: dv/tb_rgb_to_gray_or_hsv_pixel.sv
`timescale 1ns / 100ps
// Testbench for the BGR pixel converter: directed and randomized beats checked against a gray/HSV predictor.

module tb_rgb_to_gray_or_hsv_pixel;

  localparam logic ModeGray = 1'b0;
  localparam logic ModeHsv  = 1'b1;

  localparam int unsigned PipeLatency = 10;
  localparam int unsigned ItemsPerPhase = 150;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] gray_or_hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } converted_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_data_i  = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] blue_i      = '0;
  logic [7:0] green_i     = '0;
  logic [7:0] red_i       = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] gray_or_hue_o;
  logic [7:0] saturation_o;
  logic [7:0] brightness_o;

  pixel_t     pending_pixels[$];
  converted_t expected_results[$];
  logic       mode_setting = ModeGray;
  int         mismatch_count = 0;

  // Driver and receiver pacing state.
  int         burst_left = 8;
  int         gap_left = 0;
  int         stall_window = 0;
  int         stall_pct = 0;
  pixel_t     next_pixel;
  pixel_t     taken_pixel;
  converted_t seen_result;
  converted_t want_result;

  rgb_to_gray_or_hsv_pixel u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .gray_or_hue_o (gray_or_hue_o),
    .saturation_o  (saturation_o),
    .brightness_o  (brightness_o)
  );

  always #2 clk_i = ~clk_i;

  // Luma or hue/saturation/value of one pixel, all in exact integer arithmetic.
  function automatic converted_t convert_pixel(input logic hsv, input pixel_t px);
    converted_t  res;
    int unsigned b;
    int unsigned g;
    int unsigned r;
    int unsigned mx;
    int unsigned mn;
    int unsigned d;
    int unsigned num;
    b   = px.blue;
    g   = px.green;
    r   = px.red;
    res = '0;
    if (hsv == ModeGray) begin
      res.gray_or_hue = 8'((32'd7471 * b + 32'd38470 * g + 32'd19595 * r) >> 16);
    end else begin
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      res.brightness = 8'(mx);
      res.saturation = (mx == 0) ? 8'd0 : 8'((32'd255 * d) / mx);
      if (d == 0) begin
        res.gray_or_hue = 8'd0;
      end else begin
        // Red wins ties over green, and green over blue.
        if (mx == r) begin
          num = (g >= b) ? 32'd60 * (g - b) : 32'd360 * d - 32'd60 * (b - g);
        end else if (mx == g) begin
          num = 32'd120 * d + 32'd60 * b - 32'd60 * r;
        end else begin
          num = 32'd240 * d + 32'd60 * r - 32'd60 * g;
        end
        res.gray_or_hue = 8'(num / (32'd2 * d));
      end
    end
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      px;
    logic [7:0]  v;
    logic [7:0]  w;
    int unsigned odd;
    v   = 8'($urandom_range(255));
    w   = 8'($urandom_range(v));
    odd = $urandom_range(2);
    px  = pixel_t'($urandom);
    case ($urandom_range(9))
      0: px = '{v, v, v};
      1, 2: begin
        // Two channels share the maximum and the third lies at or below it.
        px = '{v, v, v};
        if (odd == 0) px.blue = w;
        else if (odd == 1) px.green = w;
        else px.red = w;
      end
      3: begin
        if ($urandom_range(1)) px.blue = 8'hff; else px.blue = 8'h00;
        if ($urandom_range(1)) px.red = 8'hff;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: bursts of beats with random gaps; a stalled beat is held unchanged.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      blue_i     <= '0;
      green_i    <= '0;
      red_i      <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        taken_pixel = '{blue_i, green_i, red_i};
        expected_results.push_back(convert_pixel(mode_setting, taken_pixel));
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0 || pending_pixels.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          next_pixel = pending_pixels.pop_front();
          in_valid_i <= 1'b1;
          blue_i     <= next_pixel.blue;
          green_i    <= next_pixel.green;
          red_i      <= next_pixel.red;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 24);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Monitor: checks each accepted result beat and stalls in windows of varying density.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_result = '{gray_or_hue_o, saturation_o, brightness_o};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, seen_result);
          mismatch_count++;
        end else begin
          want_result = expected_results.pop_front();
          check_field("gray_or_hue", want_result.gray_or_hue, seen_result.gray_or_hue);
          check_field("saturation", want_result.saturation, seen_result.saturation);
          check_field("brightness", want_result.brightness, seen_result.brightness);
        end
      end
      if (stall_window == 0) begin
        stall_window = $urandom_range(8, 60);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
      end else begin
        stall_window--;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // The idle check runs on the falling edge, after the driver's updates have settled.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    mode_setting = m;
  endtask

  task automatic push_directed();
    pending_pixels.push_back('{8'd0, 8'd0, 8'd0});
    pending_pixels.push_back('{8'd255, 8'd255, 8'd255});
    pending_pixels.push_back('{8'd0, 8'd0, 8'd255});
    pending_pixels.push_back('{8'd0, 8'd255, 8'd0});
    pending_pixels.push_back('{8'd255, 8'd0, 8'd0});
    pending_pixels.push_back('{8'd255, 8'd0, 8'd255});
    pending_pixels.push_back('{8'd0, 8'd255, 8'd255});
    pending_pixels.push_back('{8'd255, 8'd255, 8'd0});
    pending_pixels.push_back('{8'd128, 8'd128, 8'd128});
    pending_pixels.push_back('{8'd0, 8'd0, 8'd1});
    pending_pixels.push_back('{8'd200, 8'd10, 8'd100});
    pending_pixels.push_back('{8'd50, 8'd100, 8'd200});
  endtask

  initial begin
    logic phase_modes[5];
    phase_modes = '{ModeHsv, ModeGray, ModeHsv, ModeGray, ModeHsv};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first pass relies on the reset value of the mode register.
    push_directed();
    wait_idle();
    write_mode(ModeHsv);
    push_directed();
    wait_idle();
    write_mode(ModeGray);
    pending_pixels.push_back('{8'd255, 8'd128, 8'd1});
    wait_idle();

    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      repeat (ItemsPerPhase) pending_pixels.push_back(random_pixel());
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
